>>> src/sps_pkg.sv
// sps_pkg: shared types and constants for the sparse parameter store.
// Beat structs, window map constants, command/status/config codes.
// No dependencies.
package sps_pkg;

    localparam int ADDR_W  = 14;
    localparam int BYTE_W  = 7;
    localparam int WDATA_W = 16;
    localparam int RDATA_W = 14;
    localparam int PADB_W  = 8;
    localparam int CFG_W   = 14;

    localparam logic [ADDR_W-1:0] ADDR_MAX          = 14'd16383;
    localparam logic [ADDR_W-1:0] DISCARD_LIMIT_RST = 14'd2326;

    localparam logic [ADDR_W-1:0] WIN0_HI  = 14'd106;
    localparam logic [ADDR_W-1:0] WIN1_LO  = 14'd192;
    localparam logic [ADDR_W-1:0] WIN1_HI  = 14'd1058;
    localparam logic [ADDR_W-1:0] WIN1_OFS = 14'd85;
    localparam logic [ADDR_W-1:0] WIN2_LO  = 14'd2064;
    localparam logic [ADDR_W-1:0] WIN2_HI  = 14'd2106;
    localparam logic [ADDR_W-1:0] WIN2_OFS = 14'd1090;
    localparam logic [ADDR_W-1:0] WIN3_LO  = 14'd2304;
    localparam logic [ADDR_W-1:0] WIN3_HI  = 14'd2326;
    localparam logic [ADDR_W-1:0] WIN3_OFS = 14'd1287;

    localparam logic [WDATA_W-1:0] VAL1_MAX = 16'd127;
    localparam logic [WDATA_W-1:0] VAL2_MAX = 16'd16383;

    localparam logic [1:0] CMD_VAL_RD = 2'd0;
    localparam logic [1:0] CMD_VAL_WR = 2'd1;
    localparam logic [1:0] CMD_RAW_RD = 2'd2;
    localparam logic [1:0] CMD_RAW_WR = 2'd3;

    localparam logic [1:0] ST_MAPPED = 2'd0;
    localparam logic [1:0] ST_PADDED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [1:0] CFG_PAD_VALUE     = 2'd0;
    localparam logic [1:0] CFG_PAD_BYTE      = 2'd1;
    localparam logic [1:0] CFG_DISCARD_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_READ,
        MEM_WRITE
    } mem_op_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [ADDR_W:0]    address;
        logic               width_two;
        logic [WDATA_W-1:0] wdata;
        logic               final_req;
    } sps_in_t;

    typedef struct packed {
        logic [RDATA_W-1:0] rdata;
        logic [1:0]         status;
        logic [1:0]         bytes_done;
        logic               last;
    } sps_out_t;

    typedef struct packed {
        mem_op_t            op;
        logic               two;
        logic [1:0]         status;
        logic [1:0]         done;
        logic [RDATA_W-1:0] rdata;
        logic [BYTE_W-1:0]  wb0;
        logic [BYTE_W-1:0]  wb1;
        logic               last;
    } sps_plan_t;

endpackage

>>> src/sps_addr_map.sv
// sps_addr_map: decodes one input beat into an access plan and a dense index.
// Window mapping, discard limit, range and value checks.
// Depends on sps_pkg.
module sps_addr_map
    import sps_pkg::*;
#(
    parameter int STORE_DEPTH = 1040,
    localparam int AW = $clog2(STORE_DEPTH)
)
(
    input  sps_in_t             in_beat,
    input  logic [ADDR_W-1:0]   discard_limit,
    input  logic [ADDR_W-1:0]   padding_value,
    input  logic [PADB_W-1:0]   padding_byte,
    output sps_plan_t           plan,
    output logic [AW-1:0]       idx
);

    function automatic logic [ADDR_W:0] map_addr(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] lim);
        logic              ok;
        logic [ADDR_W-1:0] i;
        ok = 1'b1;
        i  = a;
        if (a <= WIN0_HI)
            i = a;
        else if (a < WIN1_LO)
            ok = 1'b0;
        else if (a <= WIN1_HI)
            i = a - WIN1_OFS;
        else if (a < WIN2_LO)
            ok = 1'b0;
        else if (a <= WIN2_HI)
            i = a - WIN2_OFS;
        else if (a < WIN3_LO)
            ok = 1'b0;
        else if (a <= WIN3_HI)
            i = a - WIN3_OFS;
        else
            ok = 1'b0;
        if (a > lim)
            ok = 1'b0;
        if (int'(i) >= STORE_DEPTH)
            ok = 1'b0;
        return {ok, i};
    endfunction

    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W:0]   ra;
    logic [ADDR_W:0]   rb;
    logic              ma;
    logic              mb;
    logic              raw;
    logic              val_bad;

    always_comb
    begin
        a   = in_beat.address[ADDR_W-1:0];
        a1  = a + 1'b1;
        ra  = map_addr(a, discard_limit);
        rb  = map_addr(a1, discard_limit);
        ma  = ra[ADDR_W];
        mb  = in_beat.width_two ? rb[ADDR_W] : ma;
        idx = ra[AW-1:0];
        raw = (in_beat.command == CMD_RAW_RD) || (in_beat.command == CMD_RAW_WR);

        val_bad = (in_beat.width_two && (a == ADDR_MAX))
               || ((in_beat.command == CMD_VAL_WR)
                   && (in_beat.wdata > (in_beat.width_two ? VAL2_MAX : VAL1_MAX)))
               || (ma != mb);

        plan.op     = MEM_NONE;
        plan.two    = 1'b0;
        plan.status = ST_ERROR;
        plan.done   = 2'd0;
        plan.rdata  = '0;
        plan.wb0    = in_beat.wdata[BYTE_W-1:0];
        plan.wb1    = in_beat.wdata[BYTE_W-1:0];
        plan.last   = in_beat.final_req;

        if (!in_beat.address[ADDR_W])
        begin
            if (raw)
            begin
                if (ma)
                begin
                    plan.status = ST_MAPPED;
                    plan.done   = 2'd1;
                    plan.op     = (in_beat.command == CMD_RAW_RD) ? MEM_READ : MEM_WRITE;
                end
                else
                begin
                    plan.status = ST_PADDED;
                    if (in_beat.command == CMD_RAW_RD)
                        plan.rdata = {{(RDATA_W-PADB_W){1'b0}}, padding_byte};
                end
            end
            else if (!val_bad)
            begin
                if (!ma)
                begin
                    plan.status = ST_PADDED;
                    if (in_beat.command == CMD_VAL_RD)
                        plan.rdata = padding_value;
                end
                else
                begin
                    plan.status = ST_MAPPED;
                    plan.op     = (in_beat.command == CMD_VAL_RD) ? MEM_READ : MEM_WRITE;
                    plan.two    = in_beat.width_two;
                    plan.done   = in_beat.width_two ? 2'd2 : 2'd1;
                    if (in_beat.width_two)
                        plan.wb0 = in_beat.wdata[2*BYTE_W-1:BYTE_W];
                end
            end
        end
    end

endmodule

>>> src/sps_ram.sv
// sps_ram: single-port byte memory with registered read data.
// One read or write per cycle. Depends on sps_pkg.
module sps_ram
    import sps_pkg::*;
#(
    parameter int STORE_DEPTH = 1040,
    localparam int AW = $clog2(STORE_DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule

>>> src/sparse_parameter_store.sv
// sparse_parameter_store: top level, access sequencer, config registers.
// Instantiates sps_addr_map and sps_ram. Depends on sps_pkg.
//
// After reset the store runs a clearing pass over all STORE_DEPTH addresses
// (1040 by default) that zeroes every byte; input stall stays high for its
// length while config writes are taken. Each access is then one pass through
// the single memory port: a one-byte or padded access goes through S_FIN into
// the output register, a two-byte value access through S_SEC and S_FIN, and
// S_FIN waits while out_stall holds the output. The next beat is taken in the
// cycle the result is loaded, so one-byte accesses sustain one beat per cycle
// unless the output stalls; two-byte ones spend S_SEC on the second byte.
module sparse_parameter_store
    import sps_pkg::*;
#(
    parameter int STORE_DEPTH = 1040
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sps_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output sps_out_t         out_data,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SEC,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    sps_plan_t         plan_reg, plan_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;
    logic              out_valid_reg, out_valid_next;
    sps_out_t          out_data_reg, out_data_next;

    logic [ADDR_W-1:0] padding_value_reg;
    logic [PADB_W-1:0] padding_byte_reg;
    logic [ADDR_W-1:0] discard_limit_reg;

    sps_plan_t         dec_plan;
    logic [AW-1:0]     dec_idx;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_q;
    logic              out_free;
    logic              accept;
    sps_out_t          result;

    sps_addr_map #(.STORE_DEPTH(STORE_DEPTH)) u_map (
        .in_beat       (in_data),
        .discard_limit (discard_limit_reg),
        .padding_value (padding_value_reg),
        .padding_byte  (padding_byte_reg),
        .plan          (dec_plan),
        .idx           (dec_idx)
    );

    sps_ram #(.STORE_DEPTH(STORE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padding_value_reg <= '0;
            padding_byte_reg  <= '0;
            discard_limit_reg <= DISCARD_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PAD_VALUE:     padding_value_reg <= cfg_wdata;
                CFG_PAD_BYTE:      padding_byte_reg  <= cfg_wdata[PADB_W-1:0];
                CFG_DISCARD_LIMIT: discard_limit_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        in_stall = !((state_reg == S_IDLE) || ((state_reg == S_FIN) && out_free));
        accept   = in_valid && !in_stall;

        result.rdata      = plan_reg.rdata;
        if (plan_reg.op == MEM_READ)
            result.rdata  = plan_reg.two ? {hi_reg, ram_q}
                                         : {{(RDATA_W-BYTE_W){1'b0}}, ram_q};
        result.status     = plan_reg.status;
        result.bytes_done = plan_reg.done;
        result.last       = plan_reg.last;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        plan_next      = plan_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = idx_reg;
        ram_wdata = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_SEC:
            begin
                ram_addr   = idx_reg + 1'b1;
                ram_we     = (plan_reg.op == MEM_WRITE);
                ram_re     = (plan_reg.op == MEM_READ);
                ram_wdata  = plan_reg.wb1;
                hi_next    = ram_q;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_data_next  = result;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (accept)
        begin
            plan_next  = dec_plan;
            idx_next   = dec_idx;
            ram_addr   = dec_idx;
            ram_we     = (dec_plan.op == MEM_WRITE);
            ram_re     = (dec_plan.op == MEM_READ);
            ram_wdata  = dec_plan.wb0;
            state_next = dec_plan.two ? S_SEC : S_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            plan_reg      <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            idx_reg       <= idx_next;
            plan_reg      <= plan_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("beat taken during clearing pass");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_ERROR))
            |-> ((out_data.rdata == '0) && (out_data.bytes_done == 2'd0)))
        else $error("error result carries data");

    a_padded_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_PADDED)) |-> (out_data.bytes_done == 2'd0))
        else $error("padded result reports stored bytes");

    a_sec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEC) |=> (state_reg == S_FIN))
        else $error("second byte cycle not followed by finish");

endmodule

>>> sim/tb_sparse_parameter_store.sv
// tb_sparse_parameter_store: self-checking testbench for sparse_parameter_store.
// Directed rows checked against their table or an in-bench windowed-store model,
// then random ones against the model. Depends on sps_pkg and the RTL in src.
module tb_sparse_parameter_store;
    import sps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STORE_DEPTH  = 1040;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          MAX_PRINTS   = 40;

    typedef struct {
        sps_in_t  beat;
        bit       typed;
        sps_out_t want;
    } access_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    sps_in_t          in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    sps_out_t         out_data;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = CFG_PAD_VALUE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [BYTE_W-1:0]  shadow_mem [STORE_DEPTH];
    logic [RDATA_W-1:0] pad_value_cfg = '0;
    logic [PADB_W-1:0]  pad_byte_cfg  = '0;
    logic [ADDR_W-1:0]  limit_cfg     = DISCARD_LIMIT_RST;

    access_row_t offered_rows [$];
    access_row_t directed_rows [$];
    sps_out_t    expected_results [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned result_count = 0;
    logic        quiet = 1'b0;
    int          hold_asks = 0;

    int unsigned window_edges [15] = '{0, 106, 107, 191, 192, 1058, 1059, 2063, 2064,
                                      2106, 2107, 2303, 2304, 2326, 2327};

    sparse_parameter_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit map_sparse(input int unsigned a, output int unsigned idx);
        int unsigned i;
        if (a > limit_cfg) return 1'b0;
        if (a <= WIN0_HI) i = a;
        else if (a < WIN1_LO) return 1'b0;
        else if (a <= WIN1_HI) i = a - WIN1_OFS;
        else if (a < WIN2_LO) return 1'b0;
        else if (a <= WIN2_HI) i = a - WIN2_OFS;
        else if (a < WIN3_LO) return 1'b0;
        else if (a <= WIN3_HI) i = a - WIN3_OFS;
        else return 1'b0;
        if (i >= STORE_DEPTH) return 1'b0;
        idx = i;
        return 1'b1;
    endfunction

    // updates shadow_mem for accepted writes
    function automatic sps_out_t predict_access(input sps_in_t b);
        sps_out_t    r;
        int unsigned a;
        int unsigned ia;
        int unsigned ib;
        bit          ma;
        bit          mb;
        bit          two;
        r.rdata      = '0;
        r.status     = ST_ERROR;
        r.bytes_done = 2'd0;
        r.last       = b.final_req;
        a   = 32'(b.address);
        two = b.width_two;
        ia  = 0;
        ib  = 0;
        if (a > ADDR_MAX) return r;
        if (b.command == CMD_RAW_RD || b.command == CMD_RAW_WR)
        begin
            ma = map_sparse(a, ia);
            if (!ma)
            begin
                r.status = ST_PADDED;
                if (b.command == CMD_RAW_RD) r.rdata = RDATA_W'(pad_byte_cfg);
            end
            else
            begin
                r.status     = ST_MAPPED;
                r.bytes_done = 2'd1;
                if (b.command == CMD_RAW_RD) r.rdata = RDATA_W'(shadow_mem[ia]);
                else shadow_mem[ia] = b.wdata[BYTE_W-1:0];
            end
            return r;
        end
        if (two && a + 1 > ADDR_MAX) return r;
        if (b.command == CMD_VAL_WR && b.wdata > (two ? VAL2_MAX : VAL1_MAX)) return r;
        ma = map_sparse(a, ia);
        if (two) mb = map_sparse(a + 1, ib);
        else mb = ma;
        if (ma != mb) return r;
        if (!ma)
        begin
            r.status = ST_PADDED;
            if (b.command == CMD_VAL_RD) r.rdata = pad_value_cfg;
            return r;
        end
        r.status     = ST_MAPPED;
        r.bytes_done = two ? 2'd2 : 2'd1;
        if (b.command == CMD_VAL_RD)
        begin
            if (two) r.rdata = {shadow_mem[ia], shadow_mem[ib]};
            else r.rdata = RDATA_W'(shadow_mem[ia]);
        end
        else if (two)
        begin
            shadow_mem[ia] = b.wdata[13:7];
            shadow_mem[ib] = b.wdata[6:0];
        end
        else
            shadow_mem[ia] = b.wdata[BYTE_W-1:0];
        return r;
    endfunction

    function automatic access_row_t row(input logic [1:0] cmd, input int unsigned addr,
                                        input bit two, input int unsigned wd, input bit fin,
                                        input bit typed, input int unsigned rd,
                                        input logic [1:0] st, input int unsigned done);
        access_row_t r;
        r.beat.command    = cmd;
        r.beat.address    = addr[ADDR_W:0];
        r.beat.width_two  = two;
        r.beat.wdata      = wd[WDATA_W-1:0];
        r.beat.final_req  = fin;
        r.typed           = typed;
        r.want.rdata      = rd[RDATA_W-1:0];
        r.want.status     = st;
        r.want.bytes_done = done[1:0];
        r.want.last       = fin;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t result %0d %s: got %0d, want %0d", $time, result_count, what,
                     got, want);
    endtask

    task automatic send_access(input access_row_t r);
        while (!quiet && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        offered_rows.push_back(r);
        in_valid <= 1'b1;
        in_data  <= r.beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [13:0] pv, input logic [13:0] pb,
                                input logic [13:0] dl);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PAD_VALUE;
        cfg_wdata <= pv;
        @(posedge clk);
        cfg_index <= CFG_PAD_BYTE;
        cfg_wdata <= pb;
        @(posedge clk);
        cfg_index <= CFG_DISCARD_LIMIT;
        cfg_wdata <= dl;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pad_value_cfg = pv;
        pad_byte_cfg  = pb[PADB_W-1:0];
        limit_cfg     = dl;
    endtask

    always @(posedge clk)
    begin
        sps_out_t want;
        access_row_t note;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("sparse_parameter_store: mismatch");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", 16'(out_data.rdata), 16'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.rdata !== want.rdata)
                        report_mismatch("rdata", 16'(out_data.rdata), 16'(want.rdata));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 16'(out_data.status), 16'(want.status));
                    if (out_data.bytes_done !== want.bytes_done)
                        report_mismatch("bytes_done", 16'(out_data.bytes_done),
                                        16'(want.bytes_done));
                    if (out_data.last !== want.last)
                        report_mismatch("last", 16'(out_data.last), 16'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                note = offered_rows.pop_front();
                want = predict_access(in_data);
                expected_results.push_back(note.typed ? note.want : want);
            end
        end
    end

    initial
    begin : stall_gen
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 29);
        end
    end

    initial
    begin : stimulus
        access_row_t b;
        int          n_items;
        int unsigned pick;
        int unsigned a;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;

        directed_rows.push_back(row(CMD_VAL_RD, 0, 0, 0, 0, 1, 0, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_VAL_WR, 0, 0, 127, 0, 1, 0, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_VAL_RD, 0, 0, 16'hFFFF, 1, 1, 127, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_VAL_WR, 5, 0, 128, 1, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_WR, 105, 1, 16383, 0, 1, 0, ST_MAPPED, 2));
        directed_rows.push_back(row(CMD_VAL_RD, 105, 1, 0, 0, 1, 16383, ST_MAPPED, 2));
        directed_rows.push_back(row(CMD_VAL_RD, 106, 1, 0, 1, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_WR, 191, 1, 5, 0, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_WR, 200, 1, 16384, 0, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_RD, 16384, 0, 0, 0, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_RAW_RD, 32767, 1, 0, 1, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_RD, 16383, 1, 0, 0, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_RD, 16383, 0, 0, 0, 1, 0, ST_PADDED, 0));
        directed_rows.push_back(row(CMD_VAL_WR, 150, 0, 3, 1, 1, 0, ST_PADDED, 0));
        directed_rows.push_back(row(CMD_RAW_RD, 150, 0, 0, 0, 1, 0, ST_PADDED, 0));
        directed_rows.push_back(row(CMD_RAW_WR, 1058, 0, 16'hFFFF, 0, 1, 0, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_RAW_RD, 1058, 1, 0, 1, 1, 127, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_RAW_WR, 1059, 0, 16'h1234, 0, 1, 0, ST_PADDED, 0));
        directed_rows.push_back(row(CMD_RAW_WR, 2064, 1, 16'h0055, 0, 0, 0, ST_MAPPED, 0));
        directed_rows.push_back(row(CMD_RAW_WR, 2304, 0, 16'hAAAA, 0, 0, 0, ST_MAPPED, 0));
        directed_rows.push_back(row(CMD_RAW_RD, 2304, 0, 0, 0, 0, 0, ST_MAPPED, 0));
        directed_rows.push_back(row(CMD_RAW_RD, 2326, 0, 0, 1, 1, 0, ST_MAPPED, 1));
        directed_rows.push_back(row(CMD_VAL_RD, 2326, 1, 0, 0, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_WR, 2303, 1, 100, 1, 1, 0, ST_ERROR, 0));
        directed_rows.push_back(row(CMD_VAL_RD, 2064, 1, 0, 0, 0, 0, ST_MAPPED, 0));
        directed_rows.push_back(row(CMD_VAL_RD, 2107, 0, 0, 1, 1, 0, ST_PADDED, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k]) send_access(directed_rows[k]);
        drain_results();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin apply_config(14'd16383, 14'd255, 14'd2326); n_items = 250; end
                1: begin apply_config(14'd0, 14'd0, 14'd0); n_items = 100; end
                2: begin
                    apply_config(14'($urandom_range(16383)), 14'($urandom_range(16383)),
                                 14'd16383);
                    n_items = 250;
                end
                3: begin
                    apply_config(14'($urandom_range(16383)), 14'($urandom_range(255)),
                                 14'($urandom_range(2400)));
                    n_items = 200;
                end
                default: begin apply_config(14'd1, 14'd128, 14'd2325); n_items = 150; end
            endcase
            for (int k = 0; k < n_items; k++)
            begin
                if (phase == 0 && k == 80) quiet <= 1'b1;
                if (phase == 0 && k == 180) quiet <= 1'b0;
                if (phase == 2 && k == 60) hold_asks <= hold_asks + 1;
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    if ($urandom_range(15) == 0) a = limit_cfg;
                    else a = window_edges[$urandom_range(14)];
                    a = (a + $urandom_range(8) - 4) & 32'h7FFF;
                end
                else if (pick < 85) a = $urandom_range(2400);
                else if (pick < 95) a = $urandom_range(16383);
                else a = $urandom_range(32767);
                b = row(2'($urandom_range(3)), a, 1'($urandom_range(1)),
                        $urandom_range(65535), 1'($urandom_range(1)), 0, 0, ST_MAPPED, 0);
                if (b.beat.command == CMD_VAL_WR && $urandom_range(9) != 0)
                    b.beat.wdata = b.beat.width_two ? 16'($urandom_range(16383))
                                                    : 16'($urandom_range(127));
                send_access(b);
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("sparse_parameter_store: match");
        else
            $display("sparse_parameter_store: mismatch");
        $finish;
    end

endmodule

>>> sim.f
src/sps_pkg.sv
src/sps_addr_map.sv
src/sps_ram.sv
src/sparse_parameter_store.sv
sim/tb_sparse_parameter_store.sv
